FILE: rtl/core/mtlb_pkg.sv
`default_nettype none

package mtlb_pkg;

	localparam int unsigned TLB_ENTRIES_DEF = 128;
	localparam int unsigned PAGE_BITS       = 12;
	localparam int unsigned VPN_W           = 32 - PAGE_BITS;
	localparam int unsigned ASID_W          = 12;

	// access kinds
	localparam logic [2:0] KIND_LOAD     = 3'd0;
	localparam logic [2:0] KIND_STORE    = 3'd1;
	localparam logic [2:0] KIND_SWAP     = 3'd2;
	localparam logic [2:0] KIND_CAS      = 3'd3;
	localparam logic [2:0] KIND_FETCH    = 3'd4;
	localparam logic [2:0] KIND_WR_DATA  = 3'd5;
	localparam logic [2:0] KIND_WR_INSTR = 3'd6;
	localparam logic [2:0] KIND_NONE     = 3'd7;

	// size codes
	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;

	// result status codes
	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_ALIGN = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_WRITE = 3'd3;
	localparam logic [2:0] ST_EXEC  = 3'd4;
	localparam logic [2:0] ST_HALT  = 3'd5;

	// configuration register indexes
	localparam logic [1:0] CFG_XLATE_EN = 2'd0;
	localparam logic [1:0] CFG_ASID     = 2'd1;
	localparam logic [1:0] CFG_KSTART   = 2'd2;
	localparam logic [1:0] CFG_KLIMIT   = 2'd3;

	typedef struct packed {
		logic [2:0]  kind;
		logic [1:0]  size_code;
		logic [31:0] address;
		logic [19:0] entry_vpn;
		logic [19:0] entry_ppn;
		logic [11:0] entry_asid;
		logic        entry_user;
		logic        entry_readable;
		logic        entry_writable;
		logic        entry_executable;
	} mtlb_req_t;

	typedef struct packed {
		logic [31:0] physical_address;
		logic [2:0]  status;
		logic        was_translated;
	} mtlb_rsp_t;

	typedef struct packed {
		logic [VPN_W-1:0]  vpn;
		logic [VPN_W-1:0]  ppn;
		logic [ASID_W-1:0] asid;
		logic              user;
		logic              readable;
		logic              writable;
		logic              executable;
	} tlb_entry_t;

	typedef struct packed {
		logic        xlate_en;
		logic [31:0] asid_word;
		logic [31:0] kstart;
		logic [31:0] klimit;
	} mtlb_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/mtlb_slot.sv
`default_nettype none

// Slot index = vpn mod TLB_ENTRIES over two register stages.
// Quotient estimate by reciprocal multiply is exact or one low, so one
// compare-subtract finishes the remainder.
module mtlb_slot #(
	parameter int unsigned TLB_ENTRIES = mtlb_pkg::TLB_ENTRIES_DEF,
	parameter int unsigned AW          = 7
) (
	input  wire logic                       clk,
	input  wire logic                       advance,
	input  wire logic [mtlb_pkg::VPN_W-1:0] vpn,
	output logic      [AW-1:0]              slot
);
	import mtlb_pkg::*;

	localparam logic [63:0] RECIP_W = 64'h0000_0000_FFFF_FFFF / 64'(TLB_ENTRIES);
	localparam logic [AW:0] N_W     = (AW+1)'(TLB_ENTRIES);

	logic [VPN_W+31:0] prod;
	logic [VPN_W-1:0]  vpn_s1;
	logic [VPN_W-1:0]  quot_s1;
	logic [VPN_W-1:0]  qn;
	logic [VPN_W-1:0]  diff;
	logic [AW:0]       rem_s2;
	logic [AW:0]       rem_fix;

	assign prod = (VPN_W+32)'(vpn) * (VPN_W+32)'(RECIP_W[31:0]);

	always_ff @(posedge clk) begin
		if (advance) begin
			vpn_s1  <= vpn;
			quot_s1 <= prod[VPN_W+31:32];
		end
	end

	assign qn   = VPN_W'(quot_s1 * VPN_W'(TLB_ENTRIES));
	assign diff = vpn_s1 - qn;

	always_ff @(posedge clk) begin
		if (advance) begin
			rem_s2 <= diff[AW:0];
		end
	end

	assign rem_fix = (rem_s2 >= N_W) ? (rem_s2 - N_W) : rem_s2;
	assign slot    = rem_fix[AW-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/mtlb_ram.sv
`default_nettype none

// Single-port entry store, registered read.
module mtlb_ram #(
	parameter int unsigned DEPTH = mtlb_pkg::TLB_ENTRIES_DEF,
	parameter int unsigned AW    = 7
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic                 we,
	input  wire logic [AW-1:0]        addr,
	input  wire mtlb_pkg::tlb_entry_t wdata,
	output mtlb_pkg::tlb_entry_t      rdata
);
	import mtlb_pkg::*;

	tlb_entry_t mem [DEPTH];
	tlb_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/mtlb_check.sv
`default_nettype none

// Alignment, window and permission checks; builds the result.
module mtlb_check (
	input  wire mtlb_pkg::mtlb_req_t  req,
	input  wire mtlb_pkg::tlb_entry_t dent,
	input  wire mtlb_pkg::tlb_entry_t ient,
	input  wire mtlb_pkg::mtlb_cfg_t  cfg,
	output mtlb_pkg::mtlb_rsp_t       rsp
);
	import mtlb_pkg::*;

	tlb_entry_t       ent;
	logic [1:0]       amask;
	logic             misaligned;
	logic             user;
	logic             need_tlb;
	logic             miss;
	logic [2:0]       xl_status;
	logic [VPN_W-1:0] vpn;

	assign vpn  = req.address[31:PAGE_BITS];
	assign ent  = (req.kind == KIND_FETCH) ? ient : dent;
	assign user = |cfg.asid_word[31:ASID_W];

	always_comb begin
		case (req.size_code)
			SIZE_BYTE: amask = 2'b00;
			SIZE_HALF: amask = 2'b01;
			default:   amask = 2'b11;
		endcase
	end

	assign misaligned = (req.kind != KIND_FETCH) && ((req.address[1:0] & amask) != 2'b00);
	assign need_tlb   = cfg.xlate_en && (user || (req.address < cfg.kstart) ||
	                                     (req.address >= cfg.klimit));
	assign miss       = (user && !ent.user) || (ent.asid != cfg.asid_word[ASID_W-1:0]) ||
	                    (ent.vpn != vpn);

	always_comb begin
		case (req.kind)
			KIND_LOAD:  xl_status = (miss || !ent.readable) ? ST_READ : ST_OK;
			KIND_STORE: xl_status = (miss || !ent.writable) ? ST_WRITE : ST_OK;
			KIND_FETCH: xl_status = (miss || !ent.executable) ? ST_EXEC : ST_OK;
			default: begin
				// swap / compare-swap: read checked first
				if (miss || !ent.readable) begin
					xl_status = ST_READ;
				end else if (!ent.writable) begin
					xl_status = ST_WRITE;
				end else begin
					xl_status = ST_OK;
				end
			end
		endcase
	end

	always_comb begin
		rsp = '0;
		if (req.kind inside {KIND_LOAD, KIND_STORE, KIND_SWAP, KIND_CAS, KIND_FETCH}) begin
			if (misaligned) begin
				rsp.status = cfg.xlate_en ? ST_ALIGN : ST_HALT;
			end else if (need_tlb) begin
				rsp.was_translated = 1'b1;
				rsp.status         = xl_status;
				if (xl_status == ST_OK) begin
					rsp.physical_address = {ent.ppn, req.address[PAGE_BITS-1:0]};
				end
			end else begin
				rsp.physical_address = req.address;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/mmu_tlb_translate_check.sv
`default_nettype none

// Channel  | Signals                      | Direction | Transfer when
// ---------+------------------------------+-----------+--------------------------
// request  | req_valid, req_stall, req    | in        | req_valid && !req_stall
// response | rsp_valid, rsp_stall, rsp    | out       | rsp_valid && !rsp_stall
// config   | cfg_we, cfg_index, cfg_wdata | in        | cfg_we
//
// One access per cycle while req_stall is low; after the request transfer it passes
// the s1, s2 and s3 registers before the response register loads.
// Stages: s1 reciprocal product, s2 remainder, s3 TLB RAM read/write,
// then the check logic into the response register.
// After reset both TLBs are swept to zero, one slot per cycle, with req_stall
// high until the last slot is written. Config writes are taken during the sweep.
// The whole pipe moves on one enable; rsp_stall with rsp_valid high freezes every stage.
module mmu_tlb_translate_check #(
	parameter int unsigned TLB_ENTRIES = mtlb_pkg::TLB_ENTRIES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire mtlb_pkg::mtlb_req_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output mtlb_pkg::mtlb_rsp_t      rsp,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [31:0]         cfg_wdata
);
	import mtlb_pkg::*;

	localparam int unsigned AW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(TLB_ENTRIES - 1);

	// config registers
	mtlb_cfg_t cfg_q;

	// pipeline control
	logic advance;
	logic accept;
	logic vld_s1, vld_s2, vld_s3;
	logic rsp_valid_q;

	// pipeline payload
	mtlb_req_t req_s1, req_s2, req_s3;
	mtlb_rsp_t rsp_q;
	mtlb_rsp_t rsp_next;

	// clear sweep
	logic          clearing_q;
	logic [AW-1:0] clr_cnt_q;

	// slot / RAM
	logic [VPN_W-1:0] vpn_src;
	logic [AW-1:0]    slot;
	logic             ram_en;
	logic [AW-1:0]    ram_addr;
	logic             d_we, i_we;
	tlb_entry_t       wr_ent;
	tlb_entry_t       dent, ient;
	logic             s2_go;

	// --- handshake ---
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = clearing_q || !advance;
	assign accept    = req_valid && !req_stall;

	// --- configuration port ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_XLATE_EN: cfg_q.xlate_en  <= cfg_wdata[0];
				CFG_ASID:     cfg_q.asid_word <= cfg_wdata;
				CFG_KSTART:   cfg_q.kstart    <= cfg_wdata;
				CFG_KLIMIT:   cfg_q.klimit    <= cfg_wdata;
				default:      cfg_q           <= cfg_q;
			endcase
		end
	end

	// --- clear sweep after reset ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == LAST_SLOT) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// --- valid chain ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			vld_s1      <= accept;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			rsp_valid_q <= vld_s3;
		end
	end

	// --- payload chain ---
	always_ff @(posedge clk) begin
		if (advance) begin
			req_s1 <= req;
			req_s2 <= req_s1;
			req_s3 <= req_s2;
			rsp_q  <= rsp_next;
		end
	end

	// entry writes index by their own VPN, accesses by the address page
	assign vpn_src = (req.kind == KIND_WR_DATA || req.kind == KIND_WR_INSTR) ?
	                 req.entry_vpn : req.address[31:PAGE_BITS];

	mtlb_slot #(
		.TLB_ENTRIES (TLB_ENTRIES),
		.AW          (AW)
	) u_slot (
		.clk     (clk),
		.advance (advance),
		.vpn     (vpn_src),
		.slot    (slot)
	);

	// --- TLB RAM access in s3 (sweep owns the port while clearing) ---
	assign s2_go    = advance && vld_s2;
	assign ram_en   = clearing_q || s2_go;
	assign ram_addr = clearing_q ? clr_cnt_q : slot;
	assign d_we     = clearing_q || (req_s2.kind == KIND_WR_DATA);
	assign i_we     = clearing_q || (req_s2.kind == KIND_WR_INSTR);

	always_comb begin
		wr_ent = '0;
		if (!clearing_q) begin
			wr_ent.vpn        = req_s2.entry_vpn;
			wr_ent.ppn        = req_s2.entry_ppn;
			wr_ent.asid       = req_s2.entry_asid;
			wr_ent.user       = req_s2.entry_user;
			wr_ent.readable   = req_s2.entry_readable;
			wr_ent.writable   = req_s2.entry_writable;
			wr_ent.executable = req_s2.entry_executable;
		end
	end

	mtlb_ram #(
		.DEPTH (TLB_ENTRIES),
		.AW    (AW)
	) u_dtlb (
		.clk   (clk),
		.en    (ram_en),
		.we    (d_we),
		.addr  (ram_addr),
		.wdata (wr_ent),
		.rdata (dent)
	);

	mtlb_ram #(
		.DEPTH (TLB_ENTRIES),
		.AW    (AW)
	) u_itlb (
		.clk   (clk),
		.en    (ram_en),
		.we    (i_we),
		.addr  (ram_addr),
		.wdata (wr_ent),
		.rdata (ient)
	);

	// --- check and result ---
	mtlb_check u_check (
		.req  (req_s3),
		.dent (dent),
		.ient (ient),
		.cfg  (cfg_q),
		.rsp  (rsp_next)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

FILE: rtl/core/mtlb_sva.sv
`default_nettype none

module mtlb_sva (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_valid,
	input wire logic                req_stall,
	input wire mtlb_pkg::mtlb_req_t req,
	input wire logic                rsp_valid,
	input wire logic                rsp_stall,
	input wire mtlb_pkg::mtlb_rsp_t rsp
);
	import mtlb_pkg::*;

	// a stalled response stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response dropped while stalled");

	// faults never carry an address
	a_fault_zero_pa: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> (rsp.physical_address == 32'd0))
		else $error("fault with nonzero physical address");

	// alignment faults are raised before any lookup
	a_align_untranslated: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_ALIGN || rsp.status == ST_HALT)
		|-> !rsp.was_translated)
		else $error("alignment fault marked as translated");

	// permission faults only come from a lookup
	a_perm_translated: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_READ || rsp.status == ST_WRITE ||
		              rsp.status == ST_EXEC) |-> rsp.was_translated)
		else $error("permission fault without lookup");

	// a stalled request stays offered and unchanged
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("request changed while stalled");

endmodule

bind mmu_tlb_translate_check mtlb_sva u_sva (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
